// File: hw/rtl/hslrgb_pkg.sv
// Shared constants and the hue ramp function of the HSL to RGB converter.
package hslrgb_pkg;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned MIX_W   = 14;   // hi and lo intermediates, at most 10000
    localparam int unsigned RAMP_W  = 20;   // ramp values, at most 600000
    localparam int unsigned SHIFT_W = 40;   // reciprocal shift of the output scaler
    localparam int unsigned MUL_W   = 29;
    localparam int unsigned PROD_W  = RAMP_W + MUL_W;

    localparam logic [HUE_W-1:0] HUE_TURN  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_THIRD = 9'd120;
    localparam logic [HUE_W-1:0] HUE_60    = 9'd60;
    localparam logic [HUE_W-1:0] HUE_180   = 9'd180;
    localparam logic [HUE_W-1:0] HUE_240   = 9'd240;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;

    localparam logic [RAMP_W-1:0] RAMP_FULL = 20'd600000;

    // Level = floor(v * 255 / 600000) = floor(17 * v / 40000).
    // 17 * ceil(2^40 / 40000) gives the exact quotient for every v up to 600000.
    localparam logic [MUL_W-1:0] SCALE_MUL = 29'd467292447;

    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [PCT_W-1:0]   pct_t;
    typedef logic [MIX_W-1:0]   mix_t;
    typedef logic [RAMP_W-1:0]  ramp_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // Piecewise-linear hue ramp: rises over 0..59, flat high to 179,
    // falls over 180..239 and stays low after that.
    function automatic ramp_t ramp_value(input mix_t lo, input mix_t hi, input hue_t h);
        mix_t                diff;
        logic [HUE_W-1:0]    fall;
        logic [5:0]          t;
        ramp_t               base;
        ramp_t               slope;
        ramp_t               top;
        ramp_t               result;
        diff  = hi - lo;
        fall  = HUE_240 - h;
        t     = (h < HUE_60) ? h[5:0] : fall[5:0];
        base  = RAMP_W'(lo) * 20'd60;
        top   = RAMP_W'(hi) * 20'd60;
        slope = RAMP_W'(diff) * RAMP_W'(t);
        if (h < HUE_60)
        begin
            result = base + slope;
        end
        else if (h < HUE_180)
        begin
            result = top;
        end
        else if (h < HUE_240)
        begin
            result = base + slope;
        end
        else
        begin
            result = base;
        end
        return result;
    endfunction

endpackage

// File: hw/rtl/hsl_to_rgb_converter_top.sv
// HSL to RGB converter: four-stage pipeline from one HSL request to one RGB request.
//
// Input channel s_*: one request per pixel with hue in degrees (reduced modulo 360),
// saturation and lightness in percent (each clamped to 100). Output channel m_*:
// one 8-bit red, green and blue triple per input request, in the same order.
// Pipeline: stage 1 reduces hue and clamps, stage 2 forms the hi and lo
// intermediates and the hue of each channel, stage 3 evaluates the three hue
// ramps, stage 4 scales them by 255/600000 through a reciprocal multiply and
// is the output register.
// m_tvalid rises once the request has passed the stage 1, 2, 3 and 4 registers.
// Throughput is one request per cycle while the receiver takes results; every
// stage, including the reciprocal multiplier of stage 4, takes a new value every
// cycle unless a stall holds it.
// Each stage holds a valid bit and loads whenever it is empty or its successor
// loads, so while the receiver stalls, empty stages keep filling and s_tready
// falls only when all four stages hold a request. No request is lost or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module hsl_to_rgb_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // hue_degrees[8:0], saturation_percent[15:9],
                                  // lightness_percent[22:16], zero [23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // red_level[7:0], green_level[15:8], blue_level[23:16]
);

    // Stage valid bits and load enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ld1, ld2, ld3, ld4;

    // Stage 1: reduced hue and clamped percentages.
    hslrgb_pkg::hue_t hue1_reg, hue1_next;
    hslrgb_pkg::pct_t sat1_reg, sat1_next;
    hslrgb_pkg::pct_t lit1_reg, lit1_next;

    // Stage 2: intermediates and per-channel hue.
    hslrgb_pkg::mix_t hi2_reg, hi2_next;
    hslrgb_pkg::mix_t lo2_reg, lo2_next;
    hslrgb_pkg::hue_t hr2_reg, hr2_next;
    hslrgb_pkg::hue_t hg2_reg, hg2_next;
    hslrgb_pkg::hue_t hb2_reg, hb2_next;

    // Stage 3: ramp values.
    hslrgb_pkg::ramp_t rr3_reg, rr3_next;
    hslrgb_pkg::ramp_t rg3_reg, rg3_next;
    hslrgb_pkg::ramp_t rb3_reg, rb3_next;

    // Stage 4: output levels.
    hslrgb_pkg::level_t red4_reg, red4_next;
    hslrgb_pkg::level_t grn4_reg, grn4_next;
    hslrgb_pkg::level_t blu4_reg, blu4_next;

    hslrgb_pkg::hue_t                   hue_in;
    hslrgb_pkg::pct_t                   sat_in;
    hslrgb_pkg::pct_t                   lit_in;
    logic [13:0]                        sl_prod;
    logic [14:0]                        hi_wide;
    logic [hslrgb_pkg::PROD_W-1:0]      prod_r;
    logic [hslrgb_pkg::PROD_W-1:0]      prod_g;
    logic [hslrgb_pkg::PROD_W-1:0]      prod_b;

    // A stage loads when it is empty or the next stage takes its request.
    assign ld4 = !v4_reg || m_tready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign s_tready = ld1;
    assign m_tvalid = v4_reg;
    assign m_tdata  = {blu4_reg, grn4_reg, red4_reg};

    assign v1_next = ld1 ? s_tvalid : v1_reg;
    assign v2_next = ld2 ? v1_reg   : v2_reg;
    assign v3_next = ld3 ? v2_reg   : v3_reg;
    assign v4_next = ld4 ? v3_reg   : v4_reg;

    // Stage 1 logic.
    assign hue_in = s_tdata[8:0];
    assign sat_in = s_tdata[15:9];
    assign lit_in = s_tdata[22:16];

    always_comb
    begin
        hue1_next = (hue_in >= hslrgb_pkg::HUE_TURN) ? hue_in - hslrgb_pkg::HUE_TURN : hue_in;
        sat1_next = (sat_in > hslrgb_pkg::PCT_MAX) ? hslrgb_pkg::PCT_MAX : sat_in;
        lit1_next = (lit_in > hslrgb_pkg::PCT_MAX) ? hslrgb_pkg::PCT_MAX : lit_in;
    end

    // Stage 2 logic: hi = 100*L + S*L below half lightness, else 100*L + 100*S - S*L.
    // Zero saturation falls out as hi = lo = 100*L, which gives grey.
    always_comb
    begin
        sl_prod = 14'(sat1_reg) * 14'(lit1_reg);
        if (lit1_reg < hslrgb_pkg::PCT_HALF)
        begin
            hi_wide = 15'(lit1_reg) * 15'd100 + 15'(sl_prod);
        end
        else
        begin
            hi_wide = 15'(lit1_reg) * 15'd100 + 15'(sat1_reg) * 15'd100 - 15'(sl_prod);
        end
        hi2_next = hi_wide[13:0];
        lo2_next = 14'(15'(lit1_reg) * 15'd200 - hi_wide);
        hg2_next = hue1_reg;
        hr2_next = (hue1_reg < hslrgb_pkg::HUE_240) ? hue1_reg + hslrgb_pkg::HUE_THIRD
                                                    : hue1_reg - hslrgb_pkg::HUE_240;
        hb2_next = (hue1_reg >= hslrgb_pkg::HUE_THIRD) ? hue1_reg - hslrgb_pkg::HUE_THIRD
                                                       : hue1_reg + hslrgb_pkg::HUE_240;
    end

    // Stage 3 logic.
    always_comb
    begin
        rr3_next = hslrgb_pkg::ramp_value(lo2_reg, hi2_reg, hr2_reg);
        rg3_next = hslrgb_pkg::ramp_value(lo2_reg, hi2_reg, hg2_reg);
        rb3_next = hslrgb_pkg::ramp_value(lo2_reg, hi2_reg, hb2_reg);
    end

    // Stage 4 logic: exact truncating division by reciprocal multiply.
    always_comb
    begin
        prod_r    = hslrgb_pkg::PROD_W'(rr3_reg) * hslrgb_pkg::PROD_W'(hslrgb_pkg::SCALE_MUL);
        prod_g    = hslrgb_pkg::PROD_W'(rg3_reg) * hslrgb_pkg::PROD_W'(hslrgb_pkg::SCALE_MUL);
        prod_b    = hslrgb_pkg::PROD_W'(rb3_reg) * hslrgb_pkg::PROD_W'(hslrgb_pkg::SCALE_MUL);
        red4_next = prod_r[hslrgb_pkg::SHIFT_W +: hslrgb_pkg::LEVEL_W];
        grn4_next = prod_g[hslrgb_pkg::SHIFT_W +: hslrgb_pkg::LEVEL_W];
        blu4_next = prod_b[hslrgb_pkg::SHIFT_W +: hslrgb_pkg::LEVEL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            hue1_reg <= hue1_next;
            sat1_reg <= sat1_next;
            lit1_reg <= lit1_next;
        end
        if (ld2)
        begin
            hi2_reg <= hi2_next;
            lo2_reg <= lo2_next;
            hr2_reg <= hr2_next;
            hg2_reg <= hg2_next;
            hb2_reg <= hb2_next;
        end
        if (ld3)
        begin
            rr3_reg <= rr3_next;
            rg3_reg <= rg3_next;
            rb3_reg <= rb3_next;
        end
        if (ld4)
        begin
            red4_reg <= red4_next;
            grn4_reg <= grn4_next;
            blu4_reg <= blu4_next;
        end
    end

    // Input back-pressure only appears once every stage holds a request.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled while the pipeline has a free stage");

    // The reduced hue is always below one full turn.
    a_hue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (hue1_reg < hslrgb_pkg::HUE_TURN))
        else $error("stage 1 hue not reduced");

    // The high intermediate never drops below the low one.
    a_hi_above_lo: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (hi2_reg >= lo2_reg))
        else $error("stage 2 hi below lo");

    // Ramp values stay within full scale, so the levels cannot wrap.
    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (rr3_reg <= hslrgb_pkg::RAMP_FULL && rg3_reg <= hslrgb_pkg::RAMP_FULL
                    && rb3_reg <= hslrgb_pkg::RAMP_FULL))
        else $error("stage 3 ramp value out of range");

    // A request held in the output register while stalled is not overwritten.
    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output request changed while stalled");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the HSL to RGB converter stream block.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned RANDOM_PER_PHASE = 560;
    localparam int unsigned STALL_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned DIRECTED_COUNT   = 22;

    localparam int unsigned DEG_FULL    = 360;
    localparam int unsigned PERCENT_TOP = 100;
    localparam int unsigned LEVEL_TOP   = 255;
    localparam int unsigned RAMP_TOP    = 600000;

    // Packed so that red sits in the low byte, as on m_tdata.
    typedef struct packed {
        hslrgb_pkg::level_t blue;
        hslrgb_pkg::level_t green;
        hslrgb_pkg::level_t red;
    } rgb_t;

    typedef struct packed {
        logic               typed;
        hslrgb_pkg::level_t blue;
        hslrgb_pkg::level_t green;
        hslrgb_pkg::level_t red;
        hslrgb_pkg::hue_t   hue;
        hslrgb_pkg::pct_t   sat;
        hslrgb_pkg::pct_t   lit;
    } stim_row_t;

    // Rows with typed set carry their expected color; the rest use the predictor.
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        {1'b1, 8'd0,   8'd0,   8'd0,   9'd0,   7'd0,   7'd0},
        {1'b1, 8'd255, 8'd255, 8'd255, 9'd0,   7'd0,   7'd100},
        {1'b1, 8'd255, 8'd255, 8'd255, 9'd511, 7'd0,   7'd127},
        {1'b1, 8'd127, 8'd127, 8'd127, 9'd200, 7'd0,   7'd50},
        {1'b1, 8'd0,   8'd0,   8'd255, 9'd0,   7'd100, 7'd50},
        {1'b1, 8'd0,   8'd255, 8'd0,   9'd120, 7'd100, 7'd50},
        {1'b1, 8'd255, 8'd0,   8'd0,   9'd240, 7'd100, 7'd50},
        {1'b1, 8'd0,   8'd0,   8'd255, 9'd360, 7'd100, 7'd50},
        {1'b1, 8'd0,   8'd255, 8'd0,   9'd480, 7'd127, 7'd50},
        {1'b1, 8'd0,   8'd0,   8'd0,   9'd300, 7'd100, 7'd0},
        {1'b1, 8'd255, 8'd255, 8'd255, 9'd77,  7'd127, 7'd127},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd59,  7'd100, 7'd50},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd60,  7'd80,  7'd40},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd179, 7'd55,  7'd30},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd180, 7'd55,  7'd70},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd239, 7'd101, 7'd49},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd300, 7'd100, 7'd51},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd359, 7'd1,   7'd1},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd511, 7'd127, 7'd1},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd151, 7'd64,  7'd64},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd90,  7'd1,   7'd99},
        {1'b0, 8'd0,   8'd0,   8'd0,   9'd270, 7'd37,  7'd101}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = 24'd0;  // hue_degrees[8:0], saturation_percent[15:9],
                                    // lightness_percent[22:16], zero [23]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // red_level[7:0], green_level[15:8], blue_level[23:16]

    rgb_t        rgb_expected_q [$];
    bit          drive_typed  = 1'b0;
    rgb_t        drive_want   = '0;
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 61;
    int unsigned error_count   = 0;
    int unsigned stall_cycles  = 0;

    hsl_to_rgb_converter_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned hue_ramp(int unsigned lo, int unsigned hi, int unsigned h);
        if (h < 60)
        begin
            return lo * 60 + (hi - lo) * h;
        end
        if (h < 180)
        begin
            return hi * 60;
        end
        if (h < 240)
        begin
            return lo * 60 + (hi - lo) * (240 - h);
        end
        return lo * 60;
    endfunction

    function automatic hslrgb_pkg::level_t ramp_to_level(int unsigned v);
        return hslrgb_pkg::level_t'((v * LEVEL_TOP) / RAMP_TOP);
    endfunction

    function automatic rgb_t predict_rgb(hslrgb_pkg::hue_t hue_in, hslrgb_pkg::pct_t sat_in,
                                         hslrgb_pkg::pct_t lit_in);
        int unsigned hue;
        int unsigned sat;
        int unsigned lit;
        int unsigned hi;
        int unsigned lo;
        int unsigned hue_red;
        int unsigned hue_blue;
        rgb_t        color;
        hue = int'(hue_in) % DEG_FULL;
        sat = (sat_in > PERCENT_TOP) ? PERCENT_TOP : int'(sat_in);
        lit = (lit_in > PERCENT_TOP) ? PERCENT_TOP : int'(lit_in);
        if (sat == 0)
        begin
            color.red   = hslrgb_pkg::level_t'(lit * LEVEL_TOP / PERCENT_TOP);
            color.green = color.red;
            color.blue  = color.red;
        end
        else
        begin
            if (lit < 50)
            begin
                hi = lit * (PERCENT_TOP + sat);
            end
            else
            begin
                hi = (lit + sat) * PERCENT_TOP - sat * lit;
            end
            lo       = lit * 200 - hi;
            hue_red  = (hue < 240) ? hue + 120 : hue - 240;
            hue_blue = (hue >= 120) ? hue - 120 : hue + 240;
            color.red   = ramp_to_level(hue_ramp(lo, hi, hue_red));
            color.green = ramp_to_level(hue_ramp(lo, hi, hue));
            color.blue  = ramp_to_level(hue_ramp(lo, hi, hue_blue));
        end
        return color;
    endfunction

    // Mostly legal ranges, some full-width noise, some boundary values and greys.
    task automatic pick_random_hsl(output hslrgb_pkg::hue_t h, output hslrgb_pkg::pct_t s,
                                   output hslrgb_pkg::pct_t l);
        int unsigned mode;
        mode = $urandom_range(9);
        h = hslrgb_pkg::hue_t'($urandom_range(DEG_FULL - 1));
        s = hslrgb_pkg::pct_t'($urandom_range(PERCENT_TOP));
        l = hslrgb_pkg::pct_t'($urandom_range(PERCENT_TOP));
        if (mode == 6 || mode == 7)
        begin
            h = hslrgb_pkg::hue_t'($urandom);
            s = hslrgb_pkg::pct_t'($urandom);
            l = hslrgb_pkg::pct_t'($urandom);
        end
        else if (mode == 8)
        begin
            case ($urandom_range(13))
                0:       h = 9'd0;
                1:       h = 9'd59;
                2:       h = 9'd60;
                3:       h = 9'd119;
                4:       h = 9'd120;
                5:       h = 9'd179;
                6:       h = 9'd180;
                7:       h = 9'd239;
                8:       h = 9'd240;
                9:       h = 9'd299;
                10:      h = 9'd359;
                11:      h = 9'd360;
                12:      h = 9'd511;
                default: h = 9'd300;
            endcase
            case ($urandom_range(5))
                0:       s = 7'd0;
                1:       s = 7'd1;
                2:       s = 7'd99;
                3:       s = 7'd100;
                4:       s = 7'd101;
                default: s = 7'd127;
            endcase
            case ($urandom_range(7))
                0:       l = 7'd0;
                1:       l = 7'd1;
                2:       l = 7'd49;
                3:       l = 7'd50;
                4:       l = 7'd51;
                5:       l = 7'd99;
                6:       l = 7'd100;
                default: l = 7'd127;
            endcase
        end
        else if (mode == 9)
        begin
            h = hslrgb_pkg::hue_t'($urandom);
            s = 7'd0;
            l = hslrgb_pkg::pct_t'($urandom);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_hsl(hslrgb_pkg::hue_t h, hslrgb_pkg::pct_t s, hslrgb_pkg::pct_t l,
                            bit typed, rgb_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        drive_typed = typed;
        drive_want  = want;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, l, s, h};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        rgb_t got;
        rgb_t want;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                if (drive_typed)
                begin
                    rgb_expected_q.push_back(drive_want);
                end
                else
                begin
                    rgb_expected_q.push_back(predict_rgb(s_tdata[8:0], s_tdata[15:9],
                                                         s_tdata[22:16]));
                end
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                got   = m_tdata;
                if (rgb_expected_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("unexpected result request: r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue);
                    end
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display({"mismatch: expected r=%0d g=%0d b=%0d, ",
                                      "got r=%0d g=%0d b=%0d"},
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        hslrgb_pkg::hue_t h;
        hslrgb_pkg::pct_t s;
        hslrgb_pkg::pct_t l;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_hsl(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].lit,
                     directed_rows[i].typed,
                     {directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red});
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 17;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (RANDOM_PER_PHASE)
            begin
                pick_random_hsl(h, s, l);
                send_hsl(h, s, l, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (rgb_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
